>>> sv/route_track_statistics_top_assert.svh
// Assertion macros for the route track statistics top module.
// The asserting module must have clk and arst_n in scope.
`ifndef ROUTE_TRACK_STATISTICS_TOP_ASSERT_SVH
`define ROUTE_TRACK_STATISTICS_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only out of reset
`define RTS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("route_track_statistics: assertion failed");
// Checked at every edge, reset included
`define RTS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("route_track_statistics: invariant violated");
`else
`define RTS_ASSERT(lbl, prop)
`define RTS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/rts_pkg.sv
package rts_pkg;

	// Fixed field widths
	localparam int IN_COORD_W = 32;
	localparam int ALT_BITS   = 25;
	localparam int OUT_BITS   = 40;
	localparam int HILL_BITS  = 16;

	// Hilliness: climb * 54067 / length, one extra quotient bit detects overflow
	localparam int FACTOR_BITS = 16;
	localparam logic [FACTOR_BITS-1:0] HILL_FACTOR = 16'd54067;
	localparam int HILL_STEPS = HILL_BITS + 1;

	// Stream layout
	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 152;
	localparam int E_LSB = 0;
	localparam int N_LSB = IN_COORD_W;
	localparam int U_LSB = 2 * IN_COORD_W;
	localparam int A_LSB = 3 * IN_COORD_W;
	localparam int M_PAD = M_TDATA_W - (2 * OUT_BITS + 2 * ALT_BITS + HILL_BITS);

	localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

	// Handshake status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} rts_unit_sts_t;

endpackage

>>> sv/rts_dist.sv
// Segment length: floor(sqrt(de^2 + dn^2 + du^2)).
// The three squares are summed in one serial accumulator (one multiplier bit per
// cycle, one narrow adder on the upper half), followed by a digit-by-digit square
// root (two radicand bits per cycle).
module rts_dist #(
	parameter int COORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [COORD_BITS:0]         mag_e,
	input  logic [COORD_BITS:0]         mag_n,
	input  logic [COORD_BITS:0]         mag_u,
	output logic [COORD_BITS+1:0]       root,
	output rts_pkg::rts_unit_sts_t      sts
);

	localparam int MW    = COORD_BITS + 1;   // delta magnitude
	localparam int HW    = MW + 2;           // upper product half
	localparam int HS_W  = HW + 1;           // upper half before shift
	localparam int SQ_W  = 2 * MW + 2;       // sum of squares
	localparam int NR    = SQ_W / 2;         // root digits
	localparam int RT_W  = NR;
	localparam int REM_W = NR + 2;
	localparam int CNT_W = $clog2(NR + 1);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_MUL  = 3'b010,
		U_SQRT = 3'b100
	} ustate_t;

	ustate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [MW-1:0]      me_q, mn_q, mu_q;
	logic [MW-1:0]      be_q, bn_q, bu_q;
	logic [HW-1:0]      hi_q;
	logic [MW-1:0]      lo_q;
	logic [SQ_W-1:0]    rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [RT_W-1:0]    root_q;

	logic [HS_W-1:0]    hsum;
	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   trial;
	logic               fits;
	logic               mul_last;
	logic               sqrt_last;

	// Partial products of the three squares and one root digit
	always_comb begin
		hsum = HS_W'(hi_q)
			+ (be_q[0] ? HS_W'(me_q) : '0)
			+ (bn_q[0] ? HS_W'(mn_q) : '0)
			+ (bu_q[0] ? HS_W'(mu_q) : '0);
		rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
		trial = {root_q, 2'b01};
		fits = rem_sh >= trial;
		mul_last = cnt_q == CNT_W'(MW - 1);
		sqrt_last = cnt_q == CNT_W'(NR - 1);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == U_SQRT) && sqrt_last;
			case (state_q)
				U_IDLE: begin
					cnt_q <= '0;
					if (start) state_q <= U_MUL;
				end
				U_MUL: begin
					if (mul_last) begin
						cnt_q <= '0;
						state_q <= U_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				U_SQRT: begin
					if (sqrt_last) begin
						state_q <= U_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				me_q <= mag_e;
				mn_q <= mag_n;
				mu_q <= mag_u;
				be_q <= mag_e;
				bn_q <= mag_n;
				bu_q <= mag_u;
				hi_q <= '0;
				lo_q <= '0;
			end
			U_MUL: begin
				hi_q <= hsum[HS_W-1:1];
				lo_q <= {hsum[0], lo_q[MW-1:1]};
				be_q <= be_q >> 1;
				bn_q <= bn_q >> 1;
				bu_q <= bu_q >> 1;
				rad_q <= {hsum[HS_W-1:1], hsum[0], lo_q[MW-1:1]};
				rem_q <= '0;
				root_q <= '0;
			end
			U_SQRT: begin
				rad_q <= rad_q << 2;
				if (fits) begin
					rem_q <= rem_sh - trial;
					root_q <= {root_q[RT_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[RT_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign root = root_q;
	assign sts.busy = state_q != U_IDLE;
	assign sts.done = done_q;

endmodule

>>> sv/rts_hill.sv
// Hilliness rating: climb * 54067 / length, restoring division one
// quotient bit per cycle, saturated to 16 bits.
module rts_hill #(
	parameter int DIST_BITS = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [DIST_BITS-1:0]            climb,
	input  logic [DIST_BITS-1:0]            len,
	output logic [rts_pkg::HILL_BITS-1:0]   hill,
	output rts_pkg::rts_unit_sts_t          sts
);

	localparam int NUM_W = DIST_BITS + rts_pkg::FACTOR_BITS;
	localparam int DIV_W = NUM_W + 1;
	localparam int STEPS = rts_pkg::HILL_STEPS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [DIV_W-1:0]   dvs_q;
	logic [STEPS-1:0]   quo_q;
	logic               fits;

	assign fits = {1'b0, num_q} >= dvs_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(STEPS - 1));
			if (!busy_q) begin
				cnt_q <= '0;
				busy_q <= start;
			end else if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Dividend, shifted divisor, quotient; the quotient holds until the next start
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				num_q <= NUM_W'(climb) * rts_pkg::HILL_FACTOR;
				dvs_q <= {1'b0, len, {rts_pkg::HILL_BITS{1'b0}}};
				quo_q <= '0;
			end
		end else begin
			if (fits) num_q <= num_q - dvs_q[NUM_W-1:0];
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[STEPS-2:0], fits};
		end
	end

	assign hill = quo_q[STEPS-1] ? '1 : quo_q[rts_pkg::HILL_BITS-1:0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

>>> sv/route_track_statistics_top.sv
// A first point goes from the input request through the update state to the result;
// any other point first waits for the segment length unit, that is for its serial
// squarers and then its square root.
// A last point with a route longer than 1 mm also waits for the hilliness division.
// Throughput: one point at a time; a new point is taken while a result waits.
// Reset: arst_n clears the previous point, totals and extremes to zero.
`include "route_track_statistics_top_assert.svh"

module route_track_statistics_top #(
	parameter int COORD_BITS = 32,
	parameter int DIST_BITS  = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// east[31:0], north[63:32], up[95:64], altitude[120:96], zeros above
	input  logic [rts_pkg::S_TDATA_W-1:0]   s_tdata,
	// first_point
	input  logic                            s_tuser,
	// last_point
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// point_dist[39:0], climb_total[79:40], highest_alt[104:80],
	// lowest_alt[129:105], hilliness[145:130], zeros above
	output logic [rts_pkg::M_TDATA_W-1:0]   m_tdata,
	// hilliness_valid
	output logic                            m_tlast
);

	localparam int MW    = COORD_BITS + 1;
	localparam int RT_W  = COORD_BITS + 2;
	localparam int SUM_W = ((DIST_BITS > RT_W) ? DIST_BITS : RT_W) + 1;
	localparam int OW    = (DIST_BITS > rts_pkg::OUT_BITS) ? DIST_BITS : rts_pkg::OUT_BITS;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIST = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_HILL = 5'b01000,
		ST_OUT  = 5'b10000
	} st_t;

	st_t                                    state_q;
	logic                                   start_q;
	logic                                   hill_start_q;
	logic                                   m_valid_q;

	// Route state
	logic [COORD_BITS-1:0]                  prev_e_q, prev_n_q, prev_u_q;
	logic [DIST_BITS-1:0]                   len_q, climb_q;
	logic signed [rts_pkg::ALT_BITS-1:0]    alt_high_q, alt_low_q;

	// Current point
	logic [MW-1:0]                          mag_e_q, mag_n_q, mag_u_q;
	logic                                   du_pos_q;
	logic                                   first_q, last_q;
	logic signed [rts_pkg::ALT_BITS-1:0]    alt_q;
	logic                                   hill_use_q;

	// Result register
	logic [rts_pkg::OUT_BITS-1:0]           m_dist_q, m_climb_q;
	logic [rts_pkg::ALT_BITS-1:0]           m_high_q, m_low_q;
	logic [rts_pkg::HILL_BITS-1:0]          m_hill_q;
	logic                                   m_last_q;

	logic                                   accept;
	logic [MW-1:0]                          e_ext, n_ext, u_ext;
	logic [MW-1:0]                          de, dn, du;
	logic [MW-1:0]                          mag_e_d, mag_n_d, mag_u_d;
	logic [RT_W-1:0]                        root;
	logic [SUM_W-1:0]                       len_sum, climb_sum;
	logic [DIST_BITS-1:0]                   len_new, climb_new;
	logic signed [rts_pkg::ALT_BITS-1:0]    high_new, low_new;
	logic                                   hill_go;
	logic [rts_pkg::HILL_BITS-1:0]          hill;
	logic [OW-1:0]                          len_w, climb_w;
	logic                                   out_free;
	rts_pkg::rts_unit_sts_t                 dist_sts, hill_sts;

	assign accept = s_tvalid && s_tready;
	assign s_tready = state_q == ST_IDLE;
	assign out_free = !m_valid_q || m_tready;

	// Deltas against the previous point, sign taken from bit COORD_BITS-1
	always_comb begin
		e_ext = {s_tdata[rts_pkg::E_LSB+COORD_BITS-1], s_tdata[rts_pkg::E_LSB +: COORD_BITS]};
		n_ext = {s_tdata[rts_pkg::N_LSB+COORD_BITS-1], s_tdata[rts_pkg::N_LSB +: COORD_BITS]};
		u_ext = {s_tdata[rts_pkg::U_LSB+COORD_BITS-1], s_tdata[rts_pkg::U_LSB +: COORD_BITS]};
		de = e_ext - {prev_e_q[COORD_BITS-1], prev_e_q};
		dn = n_ext - {prev_n_q[COORD_BITS-1], prev_n_q};
		du = u_ext - {prev_u_q[COORD_BITS-1], prev_u_q};
		mag_e_d = de[MW-1] ? (MW'(0) - de) : de;
		mag_n_d = dn[MW-1] ? (MW'(0) - dn) : dn;
		mag_u_d = du[MW-1] ? (MW'(0) - du) : du;
	end

	// Saturating totals and extremes for this point; a first point restarts them
	always_comb begin
		len_sum = SUM_W'(len_q) + SUM_W'(root);
		climb_sum = SUM_W'(climb_q) + SUM_W'(mag_u_q);
		if (first_q) begin
			len_new = '0;
			climb_new = '0;
			high_new = alt_q;
			low_new = alt_q;
		end else begin
			len_new = (len_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : len_sum[DIST_BITS-1:0];
			if (du_pos_q)
				climb_new = (climb_sum > SUM_W'(DIST_MAX)) ? DIST_MAX
					: climb_sum[DIST_BITS-1:0];
			else
				climb_new = climb_q;
			high_new = (alt_q > alt_high_q) ? alt_q : alt_high_q;
			low_new = (alt_q <= alt_low_q) ? alt_q : alt_low_q;
		end
		hill_go = last_q && (len_new > DIST_BITS'(1));
	end

	// Totals widened for the output clamps
	assign len_w = OW'(len_q);
	assign climb_w = OW'(climb_q);

	// Control and route state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			hill_start_q <= 1'b0;
			m_valid_q <= 1'b0;
			prev_e_q <= '0;
			prev_n_q <= '0;
			prev_u_q <= '0;
			len_q <= '0;
			climb_q <= '0;
			alt_high_q <= '0;
			alt_low_q <= '0;
		end else begin
			start_q <= (state_q == ST_IDLE) && accept && !s_tuser;
			hill_start_q <= (state_q == ST_UPD) && hill_go;
			// result register: loaded from ST_OUT, emptied when taken
			if (state_q == ST_OUT && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_e_q <= s_tdata[rts_pkg::E_LSB +: COORD_BITS];
						prev_n_q <= s_tdata[rts_pkg::N_LSB +: COORD_BITS];
						prev_u_q <= s_tdata[rts_pkg::U_LSB +: COORD_BITS];
						state_q <= s_tuser ? ST_UPD : ST_DIST;
					end
				end
				ST_DIST: begin
					if (dist_sts.done) state_q <= ST_UPD;
				end
				ST_UPD: begin
					len_q <= len_new;
					climb_q <= climb_new;
					alt_high_q <= high_new;
					alt_low_q <= low_new;
					state_q <= hill_go ? ST_HILL : ST_OUT;
				end
				ST_HILL: begin
					if (hill_sts.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Point capture and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_e_q <= mag_e_d;
			mag_n_q <= mag_n_d;
			mag_u_q <= mag_u_d;
			du_pos_q <= !du[MW-1] && (du != '0);
			first_q <= s_tuser;
			last_q <= s_tlast;
			alt_q <= s_tdata[rts_pkg::A_LSB +: rts_pkg::ALT_BITS];
		end
		if (state_q == ST_UPD) hill_use_q <= hill_go;
		if (state_q == ST_OUT && out_free) begin
			m_dist_q <= (len_w > OW'(rts_pkg::OUT_MAX)) ? rts_pkg::OUT_MAX
				: len_w[rts_pkg::OUT_BITS-1:0];
			m_climb_q <= (climb_w > OW'(rts_pkg::OUT_MAX)) ? rts_pkg::OUT_MAX
				: climb_w[rts_pkg::OUT_BITS-1:0];
			m_high_q <= alt_high_q;
			m_low_q <= alt_low_q;
			m_hill_q <= hill_use_q ? hill : '0;
			m_last_q <= last_q;
		end
	end

	// Segment length unit
	rts_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.mag_e  (mag_e_q),
		.mag_n  (mag_n_q),
		.mag_u  (mag_u_q),
		.root   (root),
		.sts    (dist_sts)
	);

	// Hilliness divider
	rts_hill #(
		.DIST_BITS(DIST_BITS)
	) u_hill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hill_start_q),
		.climb  (climb_q),
		.len    (len_q),
		.hill   (hill),
		.sts    (hill_sts)
	);

	assign m_tvalid = m_valid_q;
	assign m_tlast = m_last_q;
	assign m_tdata = {{rts_pkg::M_PAD{1'b0}}, m_hill_q, m_low_q, m_high_q, m_climb_q, m_dist_q};

	// A new request is taken only with both iterative units at rest
	`RTS_ASSERT(a_ready_units_idle, s_tready |-> (!dist_sts.busy && !hill_sts.busy))
	// The length unit reports only while the sequencer waits for it
	`RTS_ASSERT(a_dist_done_state, dist_sts.done |-> (state_q == ST_DIST))
	// The divider is never started on a route of 1 mm or less
	`RTS_ASSERT(a_hill_len, hill_start_q |-> (len_q > DIST_BITS'(1)))
	// Extremes stay ordered
	`RTS_ASSERT_ALWAYS(a_alt_order, alt_high_q >= alt_low_q)

endmodule
